[design/gpc_pkg.sv]
package gpc_pkg;

  localparam int MAX_ROWS_DEF = 8;
  localparam int FRAC = 32;
  localparam int VW = 64;
  localparam int MW = 33;
  localparam int PW = 97;
  localparam int DCNT_W = 7;

  localparam logic [MW-1:0] ONE_Q = 33'h1_0000_0000;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_PRED = 2'd1;
  localparam logic [1:0] ACT_CORR = 2'd2;

  localparam logic [1:0] REG_EQ   = 2'd0;
  localparam logic [1:0] REG_PRED = 2'd1;
  localparam logic [1:0] REG_STEP = 2'd2;

  localparam logic [1:0]  EQ_RST   = 2'd2;
  localparam logic [2:0]  PRED_RST = 3'd5;
  localparam logic [31:0] STEP_RST = 32'd42950;

  localparam logic signed [VW-1:0] WMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [VW-1:0] WMIN = 64'sh8000_0000_0000_0000;

  typedef logic signed [VW-1:0] word_t;
  typedef logic [2:0][VW-1:0] vec3_t;

  typedef struct packed {
    logic [15:0] n;
    logic [15:0] d;
  } ratio_t;

  typedef struct packed {
    logic          start;
    word_t         a;
    logic [MW-1:0] m;
    logic [MW-1:0] d;
  } sc_req_t;

  typedef struct packed {
    logic  done;
    word_t value;
  } sc_rsp_t;

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      return s[VW] ? WMIN : WMAX;
    end
    return s[VW-1:0];
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    logic signed [VW:0] s;
    s = {a[VW-1], a} - {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      return s[VW] ? WMIN : WMAX;
    end
    return s[VW-1:0];
  endfunction

  function automatic logic [MW-1:0] fact_of(input logic [2:0] k);
    logic [MW-1:0] f;
    unique case (k)
      3'd0: f = 33'd1;
      3'd1: f = 33'd1;
      3'd2: f = 33'd2;
      3'd3: f = 33'd6;
      3'd4: f = 33'd24;
      3'd5: f = 33'd120;
      3'd6: f = 33'd720;
      3'd7: f = 33'd5040;
      default: f = 33'd1;
    endcase
    return f;
  endfunction

  // Gear coefficient c_i * i! / q!, keyed by {q-1, P, i}. A zero denominator
  // marks an unsupported order pair.
  function automatic ratio_t gear_ratio(input logic qs, input logic [2:0] p,
                                        input logic [2:0] i);
    ratio_t r;
    unique case ({qs, p, i})
      7'o020: r = {16'd5, 16'd12};
      7'o021: r = {16'd1, 16'd1};
      7'o022: r = {16'd1, 16'd1};
      7'o030: r = {16'd3, 16'd8};
      7'o031: r = {16'd1, 16'd1};
      7'o032: r = {16'd3, 16'd2};
      7'o033: r = {16'd1, 16'd1};
      7'o040: r = {16'd251, 16'd720};
      7'o041: r = {16'd1, 16'd1};
      7'o042: r = {16'd11, 16'd6};
      7'o043: r = {16'd2, 16'd1};
      7'o044: r = {16'd1, 16'd1};
      7'o050: r = {16'd95, 16'd288};
      7'o051: r = {16'd1, 16'd1};
      7'o052: r = {16'd25, 16'd12};
      7'o053: r = {16'd35, 16'd12};
      7'o054: r = {16'd5, 16'd2};
      7'o055: r = {16'd1, 16'd1};
      7'o060: r = {16'd19087, 16'd60480};
      7'o061: r = {16'd1, 16'd1};
      7'o062: r = {16'd137, 16'd60};
      7'o063: r = {16'd15, 16'd4};
      7'o064: r = {16'd17, 16'd4};
      7'o065: r = {16'd3, 16'd1};
      7'o066: r = {16'd1, 16'd1};
      7'o070: r = {16'd5257, 16'd17280};
      7'o071: r = {16'd1, 16'd1};
      7'o072: r = {16'd49, 16'd20};
      7'o073: r = {16'd203, 16'd45};
      7'o074: r = {16'd49, 16'd8};
      7'o075: r = {16'd35, 16'd6};
      7'o076: r = {16'd7, 16'd2};
      7'o077: r = {16'd1, 16'd1};
      7'o130: r = {16'd1, 16'd12};
      7'o131: r = {16'd5, 16'd12};
      7'o132: r = {16'd1, 16'd1};
      7'o133: r = {16'd1, 16'd1};
      7'o140: r = {16'd19, 16'd240};
      7'o141: r = {16'd3, 16'd8};
      7'o142: r = {16'd1, 16'd1};
      7'o143: r = {16'd3, 16'd2};
      7'o144: r = {16'd1, 16'd1};
      7'o150: r = {16'd3, 16'd40};
      7'o151: r = {16'd251, 16'd720};
      7'o152: r = {16'd1, 16'd1};
      7'o153: r = {16'd11, 16'd6};
      7'o154: r = {16'd2, 16'd1};
      7'o155: r = {16'd1, 16'd1};
      7'o160: r = {16'd863, 16'd12096};
      7'o161: r = {16'd665, 16'd2016};
      7'o162: r = {16'd1, 16'd1};
      7'o163: r = {16'd25, 16'd12};
      7'o164: r = {16'd35, 16'd12};
      7'o165: r = {16'd5, 16'd2};
      7'o166: r = {16'd1, 16'd1};
      7'o170: r = {16'd1925, 16'd28224};
      7'o171: r = {16'd19087, 16'd60480};
      7'o172: r = {16'd1, 16'd1};
      7'o173: r = {16'd137, 16'd60};
      7'o174: r = {16'd15, 16'd4};
      7'o175: r = {16'd17, 16'd4};
      7'o176: r = {16'd3, 16'd1};
      7'o177: r = {16'd1, 16'd1};
      default: r = {16'd0, 16'd0};
    endcase
    return r;
  endfunction

endpackage

[design/gpc_if.sv]
interface gpc_cmd_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [2:0]           row_index;
  logic signed [63:0]   vec_x;
  logic signed [63:0]   vec_y;
  logic signed [63:0]   vec_z;
  modport source (output valid, action, row_index, vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, action, row_index, vec_x, vec_y, vec_z, output ready);
endinterface

interface gpc_res_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           out_row;
  logic signed [63:0]   out_x;
  logic signed [63:0]   out_y;
  logic signed [63:0]   out_z;
  logic                 is_last;
  logic                 status;
  modport source (output valid, out_row, out_x, out_y, out_z, is_last, status, input ready);
  modport sink (input valid, out_row, out_x, out_y, out_z, is_last, status, output ready);
endinterface

interface gpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [31:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

[design/gpc_rowmem.sv]
module gpc_rowmem #(
  parameter int DEPTH = gpc_pkg::MAX_ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  gpc_pkg::vec3_t             wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output gpc_pkg::vec3_t             rdata
);
  import gpc_pkg::*;

  vec3_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/gpc_scale.sv]
module gpc_scale (
  input  logic             clk,
  input  logic             rst,
  input  gpc_pkg::sc_req_t req,
  output gpc_pkg::sc_rsp_t rsp
);
  import gpc_pkg::*;

  localparam logic [1:0] SC_IDLE = 2'd0;
  localparam logic [1:0] SC_MUL  = 2'd1;
  localparam logic [1:0] SC_DIV  = 2'd2;
  localparam logic [1:0] SC_FIN  = 2'd3;

  logic [1:0]        st;
  logic              neg;
  logic [PW-1:0]     mcand;
  logic [MW-1:0]     mr;
  logic [PW-1:0]     prod;
  logic [PW-1:0]     dv;
  logic [MW-1:0]     rem;
  logic [MW-1:0]     dreg;
  logic [DCNT_W-1:0] cnt;
  logic              done;
  word_t             value;

  logic [VW-1:0]     mag_in;
  logic [PW-1:0]     prod_rnd;
  logic [MW:0]       r2;
  logic              ge;

  assign mag_in   = req.a[VW-1] ? (~req.a + 64'd1) : req.a;
  assign prod_rnd = prod + PW'(dreg >> 1);
  assign r2       = {rem, dv[PW-1]};
  assign ge       = r2 >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= SC_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        SC_IDLE: begin
          if (req.start) begin
            neg <= req.a[VW-1];
            if (mag_in == '0 || req.m == '0) begin
              value <= '0;
              done  <= 1'b1;
            end else if (req.d == '0) begin
              value <= req.a[VW-1] ? WMIN : WMAX;
              done  <= 1'b1;
            end else begin
              mcand <= PW'(mag_in);
              mr    <= req.m;
              prod  <= '0;
              dreg  <= req.d;
              st    <= SC_MUL;
            end
          end
        end
        SC_MUL: begin
          if (mr == '0) begin
            if (dreg == ONE_Q) begin
              dv <= prod_rnd >> FRAC;
              st <= SC_FIN;
            end else begin
              dv  <= prod_rnd;
              rem <= '0;
              cnt <= '0;
              st  <= SC_DIV;
            end
          end else begin
            if (mr[0]) begin
              prod <= prod + mcand;
            end
            mcand <= mcand << 1;
            mr    <= mr >> 1;
          end
        end
        SC_DIV: begin
          rem <= ge ? MW'(r2 - {1'b0, dreg}) : r2[MW-1:0];
          dv  <= {dv[PW-2:0], ge};
          cnt <= cnt + DCNT_W'(1);
          if (cnt == DCNT_W'(PW - 1)) begin
            st <= SC_FIN;
          end
        end
        SC_FIN: begin
          if (neg) begin
            value <= (dv > PW'(64'h8000_0000_0000_0000)) ? WMIN : word_t'(64'd0 - dv[VW-1:0]);
          end else begin
            value <= (dv > PW'(WMAX)) ? WMAX : word_t'(dv[VW-1:0]);
          end
          done <= 1'b1;
          st   <= SC_IDLE;
        end
        default: st <= SC_IDLE;
      endcase
    end
  end

  assign rsp.done  = done;
  assign rsp.value = value;

endmodule

[design/gear_predictor_corrector.sv]
// Predict and correct run one shared scaling unit per operation (up to a 33-step
// serial multiply, then a 97-step restoring divide unless the divisor is ONE_Q).
// Predict: 2P + 3(P+1)(P+2)/2 operations; correct: 3(1+|i-q|) summed over rows 0..P.
// One item is in work at a time; a result waits in the output register.
// Synchronous reset sets equation_order 2, prediction_order 5, step_size 42950;
// the row memory is not cleared and holds undefined data until loaded.
module gear_predictor_corrector #(
  parameter int MAX_ROWS = gpc_pkg::MAX_ROWS_DEF
) (
  input logic      clk,
  input logic      rst,
  gpc_cmd_if.sink  cmd,
  gpc_res_if.source res,
  gpc_cfg_if.sink  cfg
);
  import gpc_pkg::*;

  localparam int ROW_W = $clog2(MAX_ROWS);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_TP   = 5'd1;
  localparam logic [4:0] S_TPW  = 5'd2;
  localparam logic [4:0] S_TT   = 5'd3;
  localparam logic [4:0] S_TTW  = 5'd4;
  localparam logic [4:0] S_PROW = 5'd5;
  localparam logic [4:0] S_RD0  = 5'd6;
  localparam logic [4:0] S_RD1  = 5'd7;
  localparam logic [4:0] S_PMUL = 5'd8;
  localparam logic [4:0] S_PMW  = 5'd9;
  localparam logic [4:0] S_CE   = 5'd10;
  localparam logic [4:0] S_CROW = 5'd11;
  localparam logic [4:0] S_CL   = 5'd12;
  localparam logic [4:0] S_CLW  = 5'd13;
  localparam logic [4:0] S_CR   = 5'd14;
  localparam logic [4:0] S_CRW  = 5'd15;
  localparam logic [4:0] S_CADD = 5'd16;
  localparam logic [4:0] S_EMIT = 5'd17;
  localparam logic [4:0] S_ERR  = 5'd18;

  logic [4:0]       st;
  logic             corr;
  logic             e_phase;
  logic [ROW_W-1:0] i, j, k, pl, ra;
  logic [1:0]       lane;
  logic [2:0]       reps;
  vec3_t            acc, rowbuf, ev, dvec;
  word_t            v;
  logic [MW-1:0]    p;
  logic [MW-1:0]    tq [MAX_ROWS];

  logic [1:0]       eq;
  logic [2:0]       pred;
  logic [31:0]      dt;

  logic             rv;
  logic [2:0]       o_row;
  word_t            o_x, o_y, o_z;
  logic             o_last, o_status;

  sc_req_t          req;
  sc_rsp_t          rsp;
  vec3_t            rdata;
  logic             we;
  logic [ROW_W-1:0] waddr;
  vec3_t            wdata;

  logic             free;
  logic             cmd_acc;
  logic             up;
  logic [2:0]       reps_calc;
  logic             bad_pair;
  logic             rv_set;

  assign free      = !rv || res.ready;
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign up        = 3'(i) < 3'(eq);
  assign reps_calc = up ? 3'(3'(eq) - 3'(i)) : 3'(3'(i) - 3'(eq));
  assign bad_pair  = !(eq == 2'd1 || eq == 2'd2) || 32'(pred) >= MAX_ROWS
                     || gear_ratio(eq[1], pred, 3'd0).d == 16'd0;
  assign rv_set    = (st == S_EMIT || st == S_ERR) && free;

  assign cmd.ready = (st == S_IDLE);
  assign cfg.ready = 1'b1;

  always_comb begin
    req = '0;
    unique case (st)
      S_TP: begin
        req.start = 1'b1;
        req.a     = word_t'(p);
        req.m     = {1'b0, dt};
        req.d     = ONE_Q;
      end
      S_TT: begin
        req.start = 1'b1;
        req.a     = word_t'(p);
        req.m     = MW'(1);
        req.d     = fact_of(3'(k));
      end
      S_PMUL: begin
        req.start = 1'b1;
        req.a     = rowbuf[lane];
        req.m     = tq[ROW_W'(j - i)];
        req.d     = ONE_Q;
      end
      S_CL: begin
        req.start = 1'b1;
        req.a     = ev[lane];
        req.m     = MW'(gear_ratio(eq[1], 3'(pl), 3'(i)).n);
        req.d     = MW'(gear_ratio(eq[1], 3'(pl), 3'(i)).d);
      end
      S_CR: begin
        req.start = 1'b1;
        req.a     = v;
        req.m     = up ? {1'b0, dt} : ONE_Q;
        req.d     = up ? ONE_Q : {1'b0, dt};
      end
      default: req = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = i;
    wdata = acc;
    if (st == S_IDLE && cmd_acc && cmd.action == ACT_LOAD && 32'(cmd.row_index) < MAX_ROWS) begin
      we    = 1'b1;
      waddr = ROW_W'(cmd.row_index);
      wdata = {cmd.vec_z, cmd.vec_y, cmd.vec_x};
    end else if (st == S_EMIT && free) begin
      we = 1'b1;
    end
  end

  gpc_rowmem #(.DEPTH(MAX_ROWS)) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(ra),
    .rdata(rdata)
  );

  gpc_scale u_scale (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      eq   <= EQ_RST;
      pred <= PRED_RST;
      dt   <= STEP_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.addr)
        REG_EQ:   eq   <= cfg.data[1:0];
        REG_PRED: pred <= cfg.data[2:0];
        REG_STEP: dt   <= cfg.data;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      rv <= 1'b0;
    end else begin
      if (rv_set) begin
        rv <= 1'b1;
      end else if (res.ready) begin
        rv <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (cmd_acc) begin
            if (cmd.action == ACT_PRED) begin
              corr  <= 1'b0;
              pl    <= (32'(pred) >= MAX_ROWS) ? ROW_W'(MAX_ROWS - 1) : ROW_W'(pred);
              tq[0] <= ONE_Q;
              p     <= ONE_Q;
              k     <= ROW_W'(1);
              i     <= '0;
              st    <= (pred == 3'd0) ? S_PROW : S_TP;
            end else if (cmd.action == ACT_CORR) begin
              if (bad_pair) begin
                st <= S_ERR;
              end else begin
                corr    <= 1'b1;
                e_phase <= 1'b1;
                pl      <= ROW_W'(pred);
                dvec    <= {cmd.vec_z, cmd.vec_y, cmd.vec_x};
                ra      <= ROW_W'(eq);
                st      <= S_RD0;
              end
            end
          end
        end
        S_TP: st <= S_TPW;
        S_TPW: begin
          if (rsp.done) begin
            p  <= MW'(rsp.value);
            st <= S_TT;
          end
        end
        S_TT: st <= S_TTW;
        S_TTW: begin
          if (rsp.done) begin
            tq[k] <= MW'(rsp.value);
            if (k == pl) begin
              st <= S_PROW;
            end else begin
              k  <= k + ROW_W'(1);
              st <= S_TP;
            end
          end
        end
        S_PROW: begin
          acc <= '0;
          j   <= i;
          ra  <= i;
          st  <= S_RD0;
        end
        S_RD0: st <= S_RD1;
        S_RD1: begin
          rowbuf <= rdata;
          lane   <= 2'd0;
          if (!corr) begin
            st <= S_PMUL;
          end else if (e_phase) begin
            st <= S_CE;
          end else begin
            st <= S_CL;
          end
        end
        S_PMUL: st <= S_PMW;
        S_PMW: begin
          if (rsp.done) begin
            acc[lane] <= sat_add(acc[lane], rsp.value);
            if (lane == 2'd2) begin
              if (j == pl) begin
                st <= S_EMIT;
              end else begin
                j  <= j + ROW_W'(1);
                ra <= j + ROW_W'(1);
                st <= S_RD0;
              end
            end else begin
              lane <= lane + 2'd1;
              st   <= S_PMUL;
            end
          end
        end
        S_CE: begin
          for (int l = 0; l < 3; l++) begin
            ev[l] <= sat_sub(dvec[l], rowbuf[l]);
          end
          e_phase <= 1'b0;
          i       <= '0;
          st      <= S_CROW;
        end
        S_CROW: begin
          ra <= i;
          st <= S_RD0;
        end
        S_CL: st <= S_CLW;
        S_CLW: begin
          if (rsp.done) begin
            v    <= rsp.value;
            reps <= reps_calc;
            st   <= (reps_calc == 3'd0) ? S_CADD : S_CR;
          end
        end
        S_CR: st <= S_CRW;
        S_CRW: begin
          if (rsp.done) begin
            v    <= rsp.value;
            reps <= reps - 3'd1;
            st   <= (reps == 3'd1) ? S_CADD : S_CR;
          end
        end
        S_CADD: begin
          acc[lane] <= sat_add(rowbuf[lane], v);
          if (lane == 2'd2) begin
            st <= S_EMIT;
          end else begin
            lane <= lane + 2'd1;
            st   <= S_CL;
          end
        end
        S_EMIT: begin
          if (free) begin
            o_row    <= 3'(i);
            o_x      <= acc[0];
            o_y      <= acc[1];
            o_z      <= acc[2];
            o_last   <= (i == pl);
            o_status <= 1'b0;
            if (i == pl) begin
              st <= S_IDLE;
            end else begin
              i  <= i + ROW_W'(1);
              st <= corr ? S_CROW : S_PROW;
            end
          end
        end
        S_ERR: begin
          if (free) begin
            o_row    <= 3'd0;
            o_x      <= '0;
            o_y      <= '0;
            o_z      <= '0;
            o_last   <= 1'b1;
            o_status <= 1'b1;
            st       <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign res.valid   = rv;
  assign res.out_row = o_row;
  assign res.out_x   = o_x;
  assign res.out_y   = o_y;
  assign res.out_z   = o_z;
  assign res.is_last = o_last;
  assign res.status  = o_status;

endmodule
